// ===== rtl/ucs_pkg.sv =====
`timescale 1ns / 1ps

package ucs_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef enum logic [2:0] {
		COMP_SCHEMA    = 3'd0,
		COMP_AUTHORITY = 3'd1,
		COMP_PATH      = 3'd2,
		COMP_QUERY     = 3'd3,
		COMP_FRAGMENT  = 3'd4
	} comp_t;

	typedef enum logic [10:0] {
		PH_LEAD      = 11'b000_0000_0001,
		PH_SCHEMA    = 11'b000_0000_0010,
		PH_COLON     = 11'b000_0000_0100,
		PH_MAYBEAUTH = 11'b000_0000_1000,
		PH_AUTH      = 11'b000_0001_0000,
		PH_HELD      = 11'b000_0010_0000,
		PH_PATH      = 11'b000_0100_0000,
		PH_QUERY     = 11'b000_1000_0000,
		PH_FRAG      = 11'b001_0000_0000,
		PH_DONE      = 11'b010_0000_0000,
		PH_ERROR     = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       char_valid;
		logic [2:0] component;
		logic       final_result;
		logic       status;
	} result_t;

	typedef struct packed {
		phase_t     phase_d;
		logic       held_we;
		logic [7:0] held_d;
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} step_t;

	function automatic logic [7:0] lower_char(input logic [7:0] c);
		lower_char = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_BIT) : c;
	endfunction

	function automatic logic is_stop(input logic [7:0] c);
		is_stop = (c == CH_SPACE) || (c == CH_DQUOTE) || (c == CH_SQUOTE) || (c == CH_NUL);
	endfunction

endpackage

// ===== rtl/ucs_in_if.sv =====
`timescale 1ns / 1ps

interface ucs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_url;

	modport source (output valid, output char_in, output end_of_url, input ready);
	modport sink (input valid, input char_in, input end_of_url, output ready);
endinterface

// ===== rtl/ucs_out_if.sv =====
`timescale 1ns / 1ps

interface ucs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       char_valid;
	logic [2:0] component;
	logic       final_result;
	logic       status;

	modport source (output valid, output char_out, output char_valid, output component,
		output final_result, output status, input ready);
	modport sink (input valid, input char_out, input char_valid, input component,
		input final_result, input status, output ready);
endinterface

// ===== rtl/url_component_splitter_core.sv =====
`timescale 1ns / 1ps

// URL component splitter.
// in_ch carries one URL byte per transaction (char_in, end_of_url marks the
// last byte). out_ch carries result transactions: a kept character tagged
// with its component (schema, authority, path, query, fragment); the last
// result of a URL carries final_result and status (1 = bad schema).
// Each input transaction produces 0, 1 or 2 results; the end_of_url byte
// always produces at least one.
// The parse phase is updated in the same cycle the byte is accepted and the
// results are written to a four-entry result queue, so the first result is
// read out of that queue on out_ch, behind any results already waiting.
// Throughput: one input transaction per cycle while results drain at one per
// cycle; a byte that releases two results (held first path character) needs
// two output transactions. in_ch.ready is high while the queue has two free
// entries, so a stalled receiver holds off the input once three results are
// waiting. Nothing is lost while out_ch.ready is low.
// Reset clears the phase to leading-space skip and empties the queue.
module url_component_splitter_core import ucs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ucs_in_if.sink    in_ch,
	ucs_out_if.source out_ch
);

	phase_t     phase_q;
	logic [7:0] held_q;
	step_t      step;
	logic       accept;
	logic       room2;
	logic [1:0] push_n;
	logic [2:0] count;

	ucs_step u_step (
		.phase (phase_q),
		.held  (held_q),
		.c     (in_ch.char_in),
		.last  (in_ch.end_of_url),
		.step  (step)
	);

	assign in_ch.ready = room2;
	assign accept      = in_ch.valid & in_ch.ready;
	assign push_n      = accept ? step.n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
		end else if (accept) begin
			phase_q <= step.phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && step.held_we) begin
			held_q <= step.held_d;
		end
	end

	ucs_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.d0     (step.r0),
		.d1     (step.r1),
		.room2  (room2),
		.count  (count),
		.out_ch (out_ch)
	);

	a_last_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.end_of_url |=> phase_q == PH_LEAD)
		else $error("phase not back to lead after end of URL");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count == $past(count) + 3'($past(push_n))
			- 3'($past(out_ch.valid & out_ch.ready)))
		else $error("result queue count mismatch");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count <= 3'd4)
		else $error("result queue overflow");

	a_final_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.end_of_url |-> push_n != 2'd0)
		else $error("end of URL produced no result");

endmodule

// ===== rtl/ucs_step.sv =====
`timescale 1ns / 1ps

module ucs_step import ucs_pkg::*; (
	input  phase_t     phase,
	input  logic [7:0] held,
	input  logic [7:0] c,
	input  logic       last,
	output step_t      step
);

	phase_t     nx;
	logic [1:0] n;
	logic [7:0] ch0, ch1;
	comp_t      cp0, cp1;
	logic       hwe;
	logic [7:0] hd;
	logic       err;
	logic       delim;

	assign delim = (c == CH_QMARK) || (c == CH_HASH) || is_stop(c);

	always_comb begin
		nx  = phase;
		n   = 2'd0;
		ch0 = CH_NUL;
		cp0 = COMP_SCHEMA;
		ch1 = CH_NUL;
		cp1 = COMP_SCHEMA;
		hwe = 1'b0;
		hd  = c;
		unique case (phase)
			PH_LEAD: begin
				if (c == CH_SPACE || c == CH_DQUOTE || c == CH_TAB || c == CH_LBRACE) begin
					nx = phase;
				end else if (c == CH_COLON || c == CH_SLASH || c == CH_QMARK ||
						c == CH_HASH || c == CH_NUL) begin
					nx = PH_ERROR;
				end else begin
					n   = 2'd1;
					ch0 = lower_char(c);
					nx  = PH_SCHEMA;
				end
			end
			PH_SCHEMA: begin
				if (c == CH_COLON) begin
					nx = PH_COLON;
				end else if (c == CH_SLASH || c == CH_QMARK || c == CH_HASH ||
						c == CH_SPACE || c == CH_NUL) begin
					nx = PH_ERROR;
				end else begin
					n   = 2'd1;
					ch0 = lower_char(c);
				end
			end
			PH_COLON: begin
				if (c == CH_SLASH) begin
					hwe = 1'b1;
					nx  = PH_MAYBEAUTH;
				end else if (c == CH_QMARK) begin
					nx = PH_QUERY;
				end else if (c == CH_HASH) begin
					nx = PH_FRAG;
				end else if (is_stop(c)) begin
					nx = PH_DONE;
				end else begin
					hwe = 1'b1;
					nx  = PH_HELD;
				end
			end
			PH_AUTH: begin
				if (c == CH_QMARK) begin
					nx = PH_QUERY;
				end else if (c == CH_HASH) begin
					nx = PH_FRAG;
				end else if (is_stop(c)) begin
					nx = PH_DONE;
				end else if (c != CH_SLASH) begin
					n   = 2'd1;
					ch0 = c;
					cp0 = COMP_AUTHORITY;
				end else begin
					// slash closing the authority opens the path, held back
					hwe = 1'b1;
					nx  = PH_HELD;
				end
			end
			PH_MAYBEAUTH, PH_HELD: begin
				if (phase == PH_MAYBEAUTH && c == CH_SLASH) begin
					nx = PH_AUTH;
				end else if (delim) begin
					// one-character path: drop the rest of the URL
					nx = PH_DONE;
				end else begin
					n   = 2'd2;
					ch0 = held;
					cp0 = COMP_PATH;
					ch1 = c;
					cp1 = COMP_PATH;
					nx  = PH_PATH;
				end
			end
			PH_PATH: begin
				if (c == CH_QMARK) begin
					nx = PH_QUERY;
				end else if (c == CH_HASH) begin
					nx = PH_FRAG;
				end else if (is_stop(c)) begin
					nx = PH_DONE;
				end else begin
					n   = 2'd1;
					ch0 = c;
					cp0 = COMP_PATH;
				end
			end
			PH_QUERY: begin
				if (c == CH_HASH) begin
					nx = PH_FRAG;
				end else if (is_stop(c)) begin
					nx = PH_DONE;
				end else begin
					n   = 2'd1;
					ch0 = c;
					cp0 = COMP_QUERY;
				end
			end
			PH_FRAG: begin
				if (is_stop(c)) begin
					nx = PH_DONE;
				end else begin
					n   = 2'd1;
					ch0 = c;
					cp0 = COMP_FRAGMENT;
				end
			end
			PH_DONE, PH_ERROR: begin
				nx = phase;
			end
			default: begin
				nx = PH_LEAD;
			end
		endcase
	end

	assign err = (nx == PH_ERROR) || (nx == PH_LEAD) || (nx == PH_SCHEMA);

	always_comb begin
		step.held_we = hwe;
		step.held_d  = hd;
		step.phase_d = last ? PH_LEAD : nx;
		step.r0 = '{char_out: ch0, char_valid: (n != 2'd0), component: cp0,
			final_result: 1'b0, status: 1'b0};
		step.r1 = '{char_out: ch1, char_valid: 1'b1, component: cp1,
			final_result: 1'b0, status: 1'b0};
		step.n  = n;
		if (last) begin
			if (n == 2'd2) begin
				step.r1.final_result = 1'b1;
				step.r1.status       = err;
			end else begin
				// a final transaction with one or no character still carries the end marker
				step.n               = 2'd1;
				step.r0.final_result = 1'b1;
				step.r0.status       = err;
			end
		end
	end

endmodule

// ===== rtl/ucs_out_fifo.sv =====
`timescale 1ns / 1ps

module ucs_out_fifo import ucs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  result_t    d0,
	input  result_t    d1,
	output logic       room2,
	output logic [2:0] count,
	ucs_out_if.source  out_ch
);

	localparam int DEPTH = 4;

	result_t    mem_q [DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] count_q;
	logic       pop;

	assign pop   = out_ch.valid & out_ch.ready;
	assign room2 = (count_q <= 3'(DEPTH - 2));
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push_n;
			rd_q    <= rd_q + 2'(pop);
			count_q <= count_q + 3'(push_n) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_q + 2'd1] <= d1;
		end
	end

	assign out_ch.valid        = (count_q != 3'd0);
	assign out_ch.char_out     = mem_q[rd_q].char_out;
	assign out_ch.char_valid   = mem_q[rd_q].char_valid;
	assign out_ch.component    = mem_q[rd_q].component;
	assign out_ch.final_result = mem_q[rd_q].final_result;
	assign out_ch.status       = mem_q[rd_q].status;

endmodule
